@@ design/gpiolk_pkg.sv @@
// Package: register select codes, access kinds, lock key phases and reset constants
`timescale 1ns / 1ps
`default_nettype none

package gpiolk_pkg;

   // register select codes on the bus
   typedef enum logic [2:0] {
      SEL_CFG_LOW    = 3'd0,
      SEL_CFG_HIGH   = 3'd1,
      SEL_INPUT      = 3'd2,
      SEL_OUTPUT     = 3'd3,
      SEL_SET_RESET  = 3'd4,
      SEL_RESET_ONLY = 3'd5,
      SEL_LOCK       = 3'd6
   } sel_type;

   // access kind
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // lock key sequence phases
   typedef enum logic [1:0] {
      KEY_IDLE     = 2'd0,
      KEY_FIRST    = 2'd1,
      KEY_SECOND   = 2'd2,
      KEY_ARMED    = 2'd3
   } key_phase_type;

   localparam int unsigned PORT_WIDTH  = 16;
   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned NIBBLE_BITS = 4;
   localparam int unsigned KEY_BIT_POS = 16;

   localparam logic [WORD_WIDTH-1:0]  CFG_RESET     = 32'h4444_4444;
   localparam logic [NIBBLE_BITS-1:0] NIBBLE_UNUSED = 4'h4;

endpackage

`default_nettype wire

@@ design/gpiolk_ifs.sv @@
// Interfaces: request and response channels of the port register block
`timescale 1ns / 1ps
`default_nettype none

interface gpiolk_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [2:0]  reg_select;
   logic [31:0] write_data;
   logic [15:0] pins_in;

   modport source (output valid, output mode, output reg_select,
                   output write_data, output pins_in, input ready);
   modport sink   (input valid, input mode, input reg_select,
                   input write_data, input pins_in, output ready);
endinterface

interface gpiolk_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [15:0] pins_out;
   logic        lock_active;

   modport source (output valid, output read_data, output pins_out,
                   output lock_active, input ready);
   modport sink   (input valid, input read_data, input pins_out,
                   input lock_active, output ready);
endinterface

`default_nettype wire

@@ design/gpio_port_with_lock_sequence_core.sv @@
// Top level: 16-pin port register block with configuration lock key sequence
//
// One request is one bus access: read or write of cfg_low, cfg_high, input,
// output, set_reset, reset_only or lock, plus the sampled pin levels. Each
// request gives exactly one response with the read data (zero on writes),
// the output latch after the access and the lock key after the access.
// Channels are valid/ready; a transfer happens when both are high.
// A request is registered in the input register, processed into the response
// register, and can be taken by the receiver from there.
// Throughput: one request per cycle while the receiver takes responses; the
// input register and the response register each hold one item, and the state
// update is combinational mask and merge logic.
// When the receiver stalls, the response register holds its item, the input
// register fills, and req_bus.ready drops until the response is taken.
// Reset (synchronous, active high) empties both registers, sets both config
// words to 0x44444444, clears the latch, lock bits and key, and returns the
// lock sequence to idle. The key is sticky until reset.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_with_lock_sequence_core
   import gpiolk_pkg::*;
#(
   parameter int unsigned PIN_COUNT = 16
) (
   input  wire          clock,
   input  wire          reset,
   gpiolk_req_if.sink   req_bus,
   gpiolk_rsp_if.source rsp_bus
);

   localparam logic [PORT_WIDTH-1:0] PinMask =
      PORT_WIDTH'((33'd1 << PIN_COUNT) - 33'd1);

   // input register
   logic                  in_valid_ff;
   logic                  in_mode_ff;
   sel_type               in_sel_ff;
   logic [WORD_WIDTH-1:0] in_data_ff;
   logic [PORT_WIDTH-1:0] in_pins_ff;

   // port state
   logic [WORD_WIDTH-1:0] cfg_low_ff, cfg_low_in;
   logic [WORD_WIDTH-1:0] cfg_high_ff, cfg_high_in;
   logic [PORT_WIDTH-1:0] latch_ff, latch_in;
   logic [PORT_WIDTH-1:0] lock_bits_ff, lock_bits_in;
   logic                  key_ff, key_in;
   key_phase_type         phase_ff, phase_in;

   // response register
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_WIDTH-1:0] out_rdata_ff, rdata_in;

   logic                  advance;
   logic [PORT_WIDTH-1:0] lock_wbits;
   logic                  lock_wkey;

   // merge a written config word with the held one, nibble by nibble
   function automatic logic [WORD_WIDTH-1:0] merge_cfg(
      input logic [WORD_WIDTH-1:0] old_word,
      input logic [WORD_WIDTH-1:0] new_word,
      input int unsigned           first_pin,
      input logic                  key,
      input logic [PORT_WIDTH-1:0] lbits
   );
      logic [WORD_WIDTH-1:0] res;
      int unsigned           pin;
      res = '0;
      for (int unsigned n = 0; n < 8; n++) begin
         pin = first_pin + n;
         if (pin >= PIN_COUNT) begin
            res[n*NIBBLE_BITS +: NIBBLE_BITS] = NIBBLE_UNUSED;
         end else if (key && lbits[pin[3:0]]) begin
            res[n*NIBBLE_BITS +: NIBBLE_BITS] = old_word[n*NIBBLE_BITS +: NIBBLE_BITS];
         end else begin
            res[n*NIBBLE_BITS +: NIBBLE_BITS] = new_word[n*NIBBLE_BITS +: NIBBLE_BITS];
         end
      end
      return res;
   endfunction

   // handshake: input register moves on when the response slot frees
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_mode_ff <= req_bus.mode;
         in_sel_ff  <= sel_type'(req_bus.reg_select);
         in_data_ff <= req_bus.write_data;
         in_pins_ff <= req_bus.pins_in;
      end
   end

   assign lock_wbits = in_data_ff[PORT_WIDTH-1:0] & PinMask;
   assign lock_wkey  = in_data_ff[KEY_BIT_POS];

   // access decode, state update and lock key sequence
   always_comb begin
      cfg_low_in   = cfg_low_ff;
      cfg_high_in  = cfg_high_ff;
      latch_in     = latch_ff;
      lock_bits_in = lock_bits_ff;
      key_in       = key_ff;
      phase_in     = phase_ff;
      rdata_in     = '0;
      if (in_mode_ff == MODE_READ) begin
         case (in_sel_ff)
            SEL_CFG_LOW:  rdata_in = cfg_low_ff;
            SEL_CFG_HIGH: rdata_in = cfg_high_ff;
            SEL_INPUT:    rdata_in = {16'd0, in_pins_ff & PinMask};
            SEL_OUTPUT:   rdata_in = {16'd0, latch_ff};
            SEL_LOCK: begin
               rdata_in = {15'd0, key_ff, lock_bits_ff};
               if (!key_ff) begin
                  if (phase_ff == KEY_ARMED) begin
                     key_in = 1'b1;
                  end
                  phase_in = KEY_IDLE;
               end
            end
            default:      rdata_in = '0;
         endcase
      end else begin
         case (in_sel_ff)
            SEL_CFG_LOW:
               cfg_low_in = merge_cfg(cfg_low_ff, in_data_ff, 0, key_ff, lock_bits_ff);
            SEL_CFG_HIGH:
               cfg_high_in = merge_cfg(cfg_high_ff, in_data_ff, 8, key_ff, lock_bits_ff);
            SEL_OUTPUT:
               latch_in = in_data_ff[PORT_WIDTH-1:0] & PinMask;
            SEL_SET_RESET:
               latch_in = ((latch_ff & ~in_data_ff[WORD_WIDTH-1:PORT_WIDTH])
                          | in_data_ff[PORT_WIDTH-1:0]) & PinMask;
            SEL_RESET_ONLY:
               latch_in = latch_ff & ~in_data_ff[PORT_WIDTH-1:0] & PinMask;
            SEL_LOCK: begin
               if (!key_ff) begin
                  lock_bits_in = lock_wbits;
                  if (phase_ff == KEY_FIRST && !lock_wkey && lock_wbits == lock_bits_ff) begin
                     phase_in = KEY_SECOND;
                  end else if (phase_ff == KEY_SECOND && lock_wkey
                               && lock_wbits == lock_bits_ff) begin
                     phase_in = KEY_ARMED;
                  end else if (lock_wkey) begin
                     phase_in = KEY_FIRST;
                  end else begin
                     phase_in = KEY_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff   <= CFG_RESET;
         cfg_high_ff  <= CFG_RESET;
         latch_ff     <= '0;
         lock_bits_ff <= '0;
         key_ff       <= 1'b0;
         phase_ff     <= KEY_IDLE;
      end else if (advance) begin
         cfg_low_ff   <= cfg_low_in;
         cfg_high_ff  <= cfg_high_in;
         latch_ff     <= latch_in;
         lock_bits_ff <= lock_bits_in;
         key_ff       <= key_in;
         phase_ff     <= phase_in;
      end
   end

   // response register
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_rdata_ff <= rdata_in;
      end
   end

   // latch and key after the access equal the updated state registers
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.read_data   = out_rdata_ff;
   assign rsp_bus.pins_out    = latch_ff;
   assign rsp_bus.lock_active = key_ff;

`ifndef SYNTHESIS
   // the key stays set until reset
   a_key_sticky: assert property (@(posedge clock) disable iff (reset)
      key_ff |=> key_ff)
      else $error("lock key cleared without reset");

   // lock bits are frozen once the key is set
   a_lock_frozen: assert property (@(posedge clock) disable iff (reset)
      key_ff |=> $stable(lock_bits_ff))
      else $error("lock bits changed while key set");

   // unimplemented pins never drive or lock
   a_unused_pins: assert property (@(posedge clock) disable iff (reset)
      ((latch_ff | lock_bits_ff) & ~PinMask) == '0)
      else $error("unimplemented pin bit set");

   // state only moves when a request is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(latch_ff) && $stable(phase_ff))
      else $error("state changed without a request");
`endif

endmodule

`default_nettype wire
